// ----- rtl/ring_sensor_line_angle_top_macros.svh -----
// ----------------------------------------------------------------------------
// ring sensor line angle: assertion macros
// shared concurrent assertion wrappers, clocked on the rising edge, off in reset
// ----------------------------------------------------------------------------
`ifndef RING_SENSOR_LINE_ANGLE_TOP_MACROS_SVH
`define RING_SENSOR_LINE_ANGLE_TOP_MACROS_SVH

// plain property, checked every cycle out of reset
`define RSLA_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("%m: assertion failed");

// antecedent in this cycle, consequent in the next
`define RSLA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: next-cycle assertion failed");

`endif

// ----- rtl/rsla_pkg.sv -----
// ----------------------------------------------------------------------------
// rsla_pkg
// constants, trig tables and controller/datapath interface types
// ----------------------------------------------------------------------------
package rsla_pkg;

  localparam int SensorCount  = 16;
  localparam int SensorShift  = $clog2(SensorCount);
  localparam int SampleBits   = 10;
  localparam int IndexBits    = 4;
  localparam int ThrBits      = 10;
  localparam int AngleBits    = 10;
  localparam int DegBits      = 9;
  localparam int TrigBits     = 16;
  localparam int QuarterBits  = 15;
  localparam int QuarterIdx   = 7;
  localparam int HitBits      = 5;
  localparam int SumBits      = 32;
  localparam int CfgIndexBits = 1;
  localparam int ProdBits     = SampleBits + 1 + TrigBits;
  localparam int RayBits      = SumBits + TrigBits;

  localparam logic [ThrBits-1:0]   RingThrReset = 10'd350;
  localparam logic [ThrBits-1:0]   SideThrReset = 10'd600;
  localparam logic [HitBits-1:0]   HitMax       = 5'd31;
  localparam logic [DegBits-1:0]   DegFull      = 9'd360;
  localparam logic [DegBits-1:0]   DegQuarter   = 9'd90;
  localparam logic [DegBits-1:0]   DegHalf      = 9'd180;
  localparam logic [DegBits-1:0]   DegThreeQ    = 9'd270;
  localparam logic signed [AngleBits-1:0] AngleAbsent  = -10'sd1;
  localparam logic signed [AngleBits-1:0] AngleZeroVec = 10'sd90;

  typedef enum logic [CfgIndexBits-1:0] {
    RegRingThr = 1'b0,
    RegSideThr = 1'b1
  } rsla_reg_e;

  // round(16384 * sin(d deg)) for d = 0..90
  localparam logic [QuarterBits-1:0] QuarterSine [91] = '{
    15'd0,     15'd286,   15'd572,   15'd857,   15'd1143,  15'd1428,  15'd1713,
    15'd1997,  15'd2280,  15'd2563,  15'd2845,  15'd3126,  15'd3406,  15'd3686,
    15'd3964,  15'd4240,  15'd4516,  15'd4790,  15'd5063,  15'd5334,  15'd5604,
    15'd5872,  15'd6138,  15'd6402,  15'd6664,  15'd6924,  15'd7182,  15'd7438,
    15'd7692,  15'd7943,  15'd8192,  15'd8438,  15'd8682,  15'd8923,  15'd9162,
    15'd9397,  15'd9630,  15'd9860,  15'd10087, 15'd10311, 15'd10531, 15'd10749,
    15'd10963, 15'd11174, 15'd11381, 15'd11585, 15'd11786, 15'd11982, 15'd12176,
    15'd12365, 15'd12551, 15'd12733, 15'd12911, 15'd13085, 15'd13255, 15'd13421,
    15'd13583, 15'd13741, 15'd13894, 15'd14044, 15'd14189, 15'd14330, 15'd14466,
    15'd14598, 15'd14726, 15'd14849, 15'd14968, 15'd15082, 15'd15191, 15'd15296,
    15'd15396, 15'd15491, 15'd15582, 15'd15668, 15'd15749, 15'd15826, 15'd15897,
    15'd15964, 15'd16026, 15'd16083, 15'd16135, 15'd16182, 15'd16225, 15'd16262,
    15'd16294, 15'd16322, 15'd16344, 15'd16362, 15'd16374, 15'd16382, 15'd16384
  };

  // q14 sine, argument 0..360
  function automatic logic signed [TrigBits-1:0] sin_q14(input logic [DegBits-1:0] deg);
    logic [DegBits-1:0]        a;
    logic [DegBits-1:0]        r;
    logic signed [TrigBits-1:0] mag;
    a = (deg >= DegFull) ? deg - DegFull : deg;
    if (a <= DegQuarter) begin
      r = a;
    end else if (a <= DegHalf) begin
      r = DegHalf - a;
    end else if (a <= DegThreeQ) begin
      r = a - DegHalf;
    end else begin
      r = DegFull - a;
    end
    mag = $signed({1'b0, QuarterSine[r[QuarterIdx-1:0]]});
    return (a > DegHalf) ? -mag : mag;
  endfunction

  // q14 cosine as a quarter-turn shifted sine
  function automatic logic signed [TrigBits-1:0] cos_q14(input logic [DegBits-1:0] deg);
    logic [DegBits:0] s;
    s = {1'b0, deg} + {1'b0, DegQuarter};
    if (s >= {1'b0, DegFull}) begin
      s = s - {1'b0, DegFull};
    end
    return sin_q14(s[DegBits-1:0]);
  endfunction

  // truncated bearing of a ring sensor, sensor count is a power of two
  function automatic logic [DegBits-1:0] sensor_deg(input logic [IndexBits-1:0] idx);
    logic [IndexBits+DegBits-1:0] p;
    p = (IndexBits+DegBits)'(idx) * (IndexBits+DegBits)'(DegFull);
    p = p >> SensorShift;
    return p[DegBits-1:0];
  endfunction

  typedef struct packed {
    logic accept;    // input transaction taken this cycle
    logic acc_en;    // add products into the running sums
    logic ang_init;  // frame end: seed angle, restart ray counter
    logic mul_en;    // form ray cross products
    logic cmp_en;    // test sign change between neighbouring rays
    logic load_out;  // write result register, clear frame state
  } rsla_cmd_t;

  typedef struct packed {
    logic last;      // accumulated item closed the frame
    logic special;   // no hits or zero vector, angle already known
    logic done;      // ray search finished
    logic out_free;  // result register can take a new result
  } rsla_sts_t;

endpackage

// ----- rtl/rsla_ctrl.sv -----
// ----------------------------------------------------------------------------
// rsla_ctrl
// sequencer: accumulate per sample, run the per-degree ray search at frame end
// ----------------------------------------------------------------------------
`include "ring_sensor_line_angle_top_macros.svh"

module rsla_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  rsla_pkg::rsla_sts_t sts_i,
  output rsla_pkg::rsla_cmd_t cmd_o
);
  import rsla_pkg::*;

  typedef enum logic [5:0] {
    StIdle = 6'b000001,
    StAcc  = 6'b000010,
    StChk  = 6'b000100,
    StAmul = 6'b001000,
    StAcmp = 6'b010000,
    StFin  = 6'b100000
  } state_e;

  state_e state_q, state_d;

  assign in_stall_o = (state_q != StIdle);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      StIdle: begin
        cmd_o.accept = in_valid_i;
        if (in_valid_i) begin
          state_d = StAcc;
        end
      end
      StAcc: begin
        cmd_o.acc_en = 1'b1;
        state_d      = sts_i.last ? StChk : StIdle;
      end
      StChk: begin
        cmd_o.ang_init = 1'b1;
        state_d        = sts_i.special ? StFin : StAmul;
      end
      StAmul: begin
        cmd_o.mul_en = 1'b1;
        state_d      = StAcmp;
      end
      StAcmp: begin
        cmd_o.cmp_en = 1'b1;
        state_d      = sts_i.done ? StFin : StAmul;
      end
      StFin: begin
        // wait for the result register to drain
        if (sts_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  `RSLA_ASSERT_NEXT(a_accept_to_acc, clk_i, rst_ni, cmd_o.accept, state_q == StAcc)
  `RSLA_ASSERT_NEXT(a_search_end, clk_i, rst_ni, state_q == StAcmp && sts_i.done, state_q == StFin)
  `RSLA_ASSERT_NEXT(a_fin_release, clk_i, rst_ni, cmd_o.load_out, !in_stall_o)

endmodule

// ----- rtl/rsla_dp.sv -----
// ----------------------------------------------------------------------------
// rsla_dp
// threshold registers, weighted sums, ray cross products and result register
// ----------------------------------------------------------------------------
`include "ring_sensor_line_angle_top_macros.svh"

module rsla_dp (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [rsla_pkg::CfgIndexBits-1:0]    cfg_index_i,
  input  logic [rsla_pkg::ThrBits-1:0]         cfg_data_i,
  input  logic [rsla_pkg::SampleBits-1:0]      ring_sample_i,
  input  logic [rsla_pkg::IndexBits-1:0]       sensor_index_i,
  input  logic                                 frame_last_i,
  input  logic [rsla_pkg::ThrBits-1:0]         side_right_sample_i,
  input  logic [rsla_pkg::ThrBits-1:0]         side_left_sample_i,
  input  logic [rsla_pkg::ThrBits-1:0]         side_back_sample_i,
  input  rsla_pkg::rsla_cmd_t                  cmd_i,
  output rsla_pkg::rsla_sts_t                  sts_o,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic                                 line_present_o,
  output logic signed [rsla_pkg::AngleBits-1:0] line_angle_o,
  output logic                                 side_right_o,
  output logic                                 side_left_o,
  output logic                                 side_back_o
);
  import rsla_pkg::*;

  logic [ThrBits-1:0] ring_thr_q, side_thr_q;

  logic                       last_q;
  logic                       side_r_q, side_l_q, side_b_q;
  logic signed [ProdBits-1:0] prod_x_q, prod_y_q;
  logic [HitBits-1:0]         hit_cnt_q;
  logic signed [SumBits-1:0]  sum_x_q, sum_y_q;

  logic [DegBits-1:0]         k_q;
  logic signed [RayBits-1:0]  px_q, py_q;
  logic                       prev_neg_q, prev_zero_q;
  logic signed [AngleBits-1:0] ang_q;

  logic                       out_valid_q;
  logic                       present_q;
  logic signed [AngleBits-1:0] angle_q;
  logic                       o_side_r_q, o_side_l_q, o_side_b_q;

  // sample side
  logic [DegBits-1:0]          sens_deg;
  logic                        idx_ok;
  logic signed [SampleBits:0]  sample_s;
  logic                        hit;
  logic signed [ProdBits-1:0]  prod_x, prod_y;

  assign sens_deg = sensor_deg(sensor_index_i);
  assign idx_ok   = 32'(sensor_index_i) < SensorCount;
  assign sample_s = $signed({1'b0, ring_sample_i});
  assign hit      = idx_ok && (ring_sample_i > ring_thr_q) && (hit_cnt_q != HitMax);

  // signed weighting, kept apart so the select below stays a plain bit copy
  assign prod_x = sample_s * sin_q14(sens_deg);
  assign prod_y = sample_s * cos_q14(sens_deg);

  // saturating accumulate
  logic signed [SumBits+1:0] acc_x, acc_y;
  logic signed [SumBits-1:0] sat_x, sat_y;

  assign acc_x = (SumBits+2)'(sum_x_q) + (SumBits+2)'(prod_x_q);
  assign acc_y = (SumBits+2)'(sum_y_q) + (SumBits+2)'(prod_y_q);

  function automatic logic signed [SumBits-1:0] sat_sum(input logic signed [SumBits+1:0] v);
    logic [2:0] top;
    top = v[SumBits+1:SumBits-1];
    if (top == 3'b000 || top == 3'b111) begin
      return v[SumBits-1:0];
    end else if (v[SumBits+1]) begin
      return {1'b1, {(SumBits-1){1'b0}}};
    end else begin
      return {1'b0, {(SumBits-1){1'b1}}};
    end
  endfunction

  assign sat_x = sat_sum(acc_x);
  assign sat_y = sat_sum(acc_y);

  // ray test: side of ray k is x*cos(k) - y*sin(k)
  logic signed [RayBits:0]    ray;
  logic                       cur_neg, cur_zero, found;
  logic [DegBits-1:0]         d_prev;
  logic signed [AngleBits-1:0] found_ang;

  assign ray      = (RayBits+1)'(px_q) - (RayBits+1)'(py_q);
  assign cur_neg  = ray[RayBits];
  assign cur_zero = (ray == '0);
  assign found    = (k_q != '0) && !prev_neg_q && cur_neg;
  assign d_prev   = k_q - 9'd1;

  always_comb begin
    // the quadrant from 270 degrees rounds up towards the wrap, except on the ray itself
    if (d_prev < DegThreeQ || prev_zero_q) begin
      found_ang = $signed({1'b0, d_prev});
    end else if (k_q == DegFull) begin
      found_ang = '0;
    end else begin
      found_ang = $signed({1'b0, k_q});
    end
  end

  assign sts_o.last     = last_q;
  assign sts_o.special  = (hit_cnt_q == '0) || (sum_x_q == '0 && sum_y_q == '0);
  assign sts_o.done     = found || (k_q == DegFull);
  assign sts_o.out_free = !out_valid_q || !out_stall_i;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ring_thr_q <= RingThrReset;
      side_thr_q <= SideThrReset;
    end else if (cfg_valid_i) begin
      unique case (rsla_reg_e'(cfg_index_i))
        RegRingThr: ring_thr_q <= cfg_data_i;
        RegSideThr: side_thr_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // per-transaction payload and ray cross products
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      last_q   <= frame_last_i;
      side_r_q <= side_right_sample_i > side_thr_q;
      side_l_q <= side_left_sample_i > side_thr_q;
      side_b_q <= side_back_sample_i > side_thr_q;
      prod_x_q <= idx_ok ? prod_x : '0;
      prod_y_q <= idx_ok ? prod_y : '0;
    end
    if (cmd_i.mul_en) begin
      px_q <= sum_x_q * cos_q14(k_q);
      py_q <= sum_y_q * sin_q14(k_q);
    end
  end

  // frame state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_cnt_q <= '0;
      sum_x_q   <= '0;
      sum_y_q   <= '0;
    end else if (cmd_i.load_out) begin
      hit_cnt_q <= '0;
      sum_x_q   <= '0;
      sum_y_q   <= '0;
    end else begin
      if (cmd_i.accept && hit) begin
        hit_cnt_q <= hit_cnt_q + 5'd1;
      end
      if (cmd_i.acc_en) begin
        sum_x_q <= sat_x;
        sum_y_q <= sat_y;
      end
    end
  end

  // search control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q         <= '0;
      prev_neg_q  <= 1'b0;
      prev_zero_q <= 1'b0;
      ang_q       <= '0;
    end else if (cmd_i.ang_init) begin
      k_q <= '0;
      if (hit_cnt_q == '0) begin
        ang_q <= AngleAbsent;
      end else if (sum_x_q == '0 && sum_y_q == '0) begin
        ang_q <= AngleZeroVec;
      end else begin
        ang_q <= '0;
      end
    end else if (cmd_i.cmp_en) begin
      prev_neg_q  <= cur_neg;
      prev_zero_q <= cur_zero;
      if (found) begin
        ang_q <= found_ang;
      end else if (k_q != DegFull) begin
        k_q <= k_q + 9'd1;
      end
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      present_q  <= hit_cnt_q != '0;
      angle_q    <= ang_q;
      o_side_r_q <= side_r_q;
      o_side_l_q <= side_l_q;
      o_side_b_q <= side_b_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign line_present_o = present_q;
  assign line_angle_o   = angle_q;
  assign side_right_o   = o_side_r_q;
  assign side_left_o    = o_side_l_q;
  assign side_back_o    = o_side_b_q;

  `RSLA_ASSERT_NEXT(a_frame_cleared, clk_i, rst_ni, cmd_i.load_out, sum_x_q == '0 && sum_y_q == '0 && hit_cnt_q == '0)
  `RSLA_ASSERT(a_ray_bound, clk_i, rst_ni, k_q <= DegFull)
  `RSLA_ASSERT_NEXT(a_result_shown, clk_i, rst_ni, cmd_i.load_out, out_valid_q && (present_q == (angle_q != AngleAbsent)))

endmodule

// ----- rtl/ring_sensor_line_angle_top.sv -----
// ----------------------------------------------------------------------------
// ring_sensor_line_angle_top
// line bearing from a 16-sensor ring: weighted sine/cosine sums, ray search
// ----------------------------------------------------------------------------
//  channel   handshake                 payload
//  -------   -----------------------   ------------------------------------------
//  in        in_valid_i / in_stall_o   ring_sample, sensor_index, frame_last, sides
//  out       out_valid_o / out_stall_i line_present, line_angle, side flags
//  cfg       cfg_valid_i / cfg_ready_o cfg_index_i, cfg_data_i (thresholds)
//
//  a sample that does not close the frame is accepted, then accumulated
//  a closing sample is accepted, accumulated and checked, then runs up to
//  361 ray tests (each a cross-product multiply, then a subtract and sign test),
//  then the result load
//  reset is asynchronous and active low; thresholds return to 350 and 600
//  a stalled result holds; the next closing sample waits until it is taken
// ----------------------------------------------------------------------------
module ring_sensor_line_angle_top (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  logic [rsla_pkg::CfgIndexBits-1:0]     cfg_index_i,
  input  logic [rsla_pkg::ThrBits-1:0]          cfg_data_i,
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  logic [rsla_pkg::SampleBits-1:0]       ring_sample_i,
  input  logic [rsla_pkg::IndexBits-1:0]        sensor_index_i,
  input  logic                                  frame_last_i,
  input  logic [rsla_pkg::ThrBits-1:0]          side_right_sample_i,
  input  logic [rsla_pkg::ThrBits-1:0]          side_left_sample_i,
  input  logic [rsla_pkg::ThrBits-1:0]          side_back_sample_i,
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output logic                                  line_present_o,
  output logic signed [rsla_pkg::AngleBits-1:0] line_angle_o,
  output logic                                  side_right_o,
  output logic                                  side_left_o,
  output logic                                  side_back_o
);
  import rsla_pkg::*;

  rsla_cmd_t cmd;
  rsla_sts_t sts;

  rsla_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  rsla_dp u_dp (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cfg_valid_i         (cfg_valid_i),
    .cfg_ready_o         (cfg_ready_o),
    .cfg_index_i         (cfg_index_i),
    .cfg_data_i          (cfg_data_i),
    .ring_sample_i       (ring_sample_i),
    .sensor_index_i      (sensor_index_i),
    .frame_last_i        (frame_last_i),
    .side_right_sample_i (side_right_sample_i),
    .side_left_sample_i  (side_left_sample_i),
    .side_back_sample_i  (side_back_sample_i),
    .cmd_i               (cmd),
    .sts_o               (sts),
    .out_valid_o         (out_valid_o),
    .out_stall_i         (out_stall_i),
    .line_present_o      (line_present_o),
    .line_angle_o        (line_angle_o),
    .side_right_o        (side_right_o),
    .side_left_o         (side_left_o),
    .side_back_o         (side_back_o)
  );

endmodule

// ----- tb/sv/testbench.sv -----
// ----------------------------------------------------------------------------
// ring sensor line angle testbench
// drives sample frames against an in-bench model of the weighted sine/cosine
// sums, hit count and ray search, under several threshold settings, with
// random gaps on the sample side and random stalls on the result side
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import rsla_pkg::*;

  typedef struct packed {
    logic [SampleBits-1:0] sample;
    logic [IndexBits-1:0]  idx;
    logic                  last;
    logic [ThrBits-1:0]    right;
    logic [ThrBits-1:0]    left;
    logic [ThrBits-1:0]    back;
  } ring_item_t;

  typedef struct packed {
    logic                        present;
    logic signed [AngleBits-1:0] angle;
    logic                        right;
    logic                        left;
    logic                        back;
  } line_result_t;

  typedef struct packed {
    ring_item_t   item;
    logic         typed;
    line_result_t want;
  } dir_row_t;

  localparam line_result_t NoLine = '0;
  localparam int DirCount = 24;

  // reset thresholds apply here: ring 350, side 600
  localparam dir_row_t DirRows [DirCount] = '{
    // sample equal to the ring threshold is no hit, side flags only above 600
    '{'{10'd350, 4'd0, 1'b1, 10'd600, 10'd601, 10'd0}, 1'b1,
      '{1'b0, AngleAbsent, 1'b0, 1'b1, 1'b0}},
    '{'{10'd1023, 4'd0, 1'b1, 10'd1023, 10'd1023, 10'd1023}, 1'b1,
      '{1'b1, 10'sd0, 1'b1, 1'b1, 1'b1}},
    '{'{10'd351, 4'd4, 1'b1, 10'd0, 10'd0, 10'd0}, 1'b1,
      '{1'b1, 10'sd90, 1'b0, 1'b0, 1'b0}},
    '{'{10'd1023, 4'd8, 1'b1, 10'd0, 10'd1023, 10'd0}, 1'b1,
      '{1'b1, 10'sd180, 1'b0, 1'b1, 1'b0}},
    '{'{10'd1023, 4'd12, 1'b1, 10'd1023, 10'd0, 10'd1023}, 1'b1,
      '{1'b1, 10'sd270, 1'b1, 1'b0, 1'b1}},
    // opposite sensors cancel: zero vector with hits
    '{'{10'd500, 4'd0, 1'b0, 10'd1023, 10'd1023, 10'd1023}, 1'b0, NoLine},
    '{'{10'd500, 4'd8, 1'b1, 10'd0, 10'd0, 10'd0}, 1'b1,
      '{1'b1, AngleZeroVec, 1'b0, 1'b0, 1'b0}},
    // truncated bearing of the last sensor lies exactly on a ray
    '{'{10'd800, 4'd15, 1'b1, 10'd0, 10'd0, 10'd0}, 1'b1,
      '{1'b1, 10'sd337, 1'b0, 1'b0, 1'b0}},
    // full ring, side readings on early samples must be ignored
    '{'{10'd0,    4'd0,  1'b0, 10'd1023, 10'd1023, 10'd1023}, 1'b0, NoLine},
    '{'{10'd1023, 4'd1,  1'b0, 10'd1023, 10'd1023, 10'd1023}, 1'b0, NoLine},
    '{'{10'd512,  4'd2,  1'b0, 10'd1023, 10'd1023, 10'd1023}, 1'b0, NoLine},
    '{'{10'd255,  4'd3,  1'b0, 10'd1023, 10'd1023, 10'd1023}, 1'b0, NoLine},
    '{'{10'd700,  4'd4,  1'b0, 10'd1023, 10'd1023, 10'd1023}, 1'b0, NoLine},
    '{'{10'd341,  4'd5,  1'b0, 10'd1023, 10'd1023, 10'd1023}, 1'b0, NoLine},
    '{'{10'd682,  4'd6,  1'b0, 10'd1023, 10'd1023, 10'd1023}, 1'b0, NoLine},
    '{'{10'd100,  4'd7,  1'b0, 10'd1023, 10'd1023, 10'd1023}, 1'b0, NoLine},
    '{'{10'd900,  4'd8,  1'b0, 10'd1023, 10'd1023, 10'd1023}, 1'b0, NoLine},
    '{'{10'd5,    4'd9,  1'b0, 10'd1023, 10'd1023, 10'd1023}, 1'b0, NoLine},
    '{'{10'd1000, 4'd10, 1'b0, 10'd1023, 10'd1023, 10'd1023}, 1'b0, NoLine},
    '{'{10'd360,  4'd11, 1'b0, 10'd1023, 10'd1023, 10'd1023}, 1'b0, NoLine},
    '{'{10'd349,  4'd12, 1'b0, 10'd1023, 10'd1023, 10'd1023}, 1'b0, NoLine},
    '{'{10'd10,   4'd13, 1'b0, 10'd1023, 10'd1023, 10'd1023}, 1'b0, NoLine},
    '{'{10'd777,  4'd14, 1'b0, 10'd1023, 10'd1023, 10'd1023}, 1'b0, NoLine},
    '{'{10'd200,  4'd15, 1'b1, 10'd0,    10'd0,    10'd0},    1'b0, NoLine}
  };

  logic                        clk_i               = 1'b0;
  logic                        rst_ni              = 1'b0;
  logic                        cfg_valid_i         = 1'b0;
  logic                        cfg_ready_o;
  logic [CfgIndexBits-1:0]     cfg_index_i         = '0;
  logic [ThrBits-1:0]          cfg_data_i          = '0;
  logic                        in_valid_i          = 1'b0;
  logic                        in_stall_o;
  logic [SampleBits-1:0]       ring_sample_i       = '0;
  logic [IndexBits-1:0]        sensor_index_i      = '0;
  logic                        frame_last_i        = 1'b0;
  logic [ThrBits-1:0]          side_right_sample_i = '0;
  logic [ThrBits-1:0]          side_left_sample_i  = '0;
  logic [ThrBits-1:0]          side_back_sample_i  = '0;
  logic                        out_valid_o;
  logic                        out_stall_i         = 1'b0;
  logic                        line_present_o;
  logic signed [AngleBits-1:0] line_angle_o;
  logic                        side_right_o;
  logic                        side_left_o;
  logic                        side_back_o;

  // model state
  logic [ThrBits-1:0]       ring_thr = RingThrReset;
  logic [ThrBits-1:0]       side_thr = SideThrReset;
  logic signed [SumBits-1:0] sum_x   = '0;
  logic signed [SumBits-1:0] sum_y   = '0;
  logic [HitBits-1:0]       hits     = '0;

  line_result_t line_queue [$];
  int           fault_count = 0;
  int           hold_left   = 0;
  logic         idle_on     = 1'b0;
  logic         stall_on    = 1'b0;

  ring_sensor_line_angle_top dut (.*);

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #40ms;
    $display("tb: failure");
    $finish;
  end

  function automatic int q14_sin(input int deg);
    int a;
    a = deg % 360;
    if (a <= 90) return int'(QuarterSine[a]);
    if (a <= 180) return int'(QuarterSine[180 - a]);
    if (a <= 270) return -int'(QuarterSine[a - 180]);
    return -int'(QuarterSine[360 - a]);
  endfunction

  function automatic logic signed [SumBits-1:0] clamp_sum(input longint v);
    if (v > longint'(32'sh7fffffff)) return 32'sh7fffffff;
    if (v < -longint'(32'sh7fffffff) - 1) return 32'sh80000000;
    return v[SumBits-1:0];
  endfunction

  // adds one sample to the frame and, on the closing sample, works out the result
  task automatic fold_ring_sample(input ring_item_t s, output logic closes,
                                  output line_result_t res);
    int     deg;
    int     bearing;
    longint x;
    longint y;
    longint c0;
    longint c1;
    closes = s.last;
    res    = '0;
    deg    = int'(s.idx) * 360 / SensorCount;
    sum_x  = clamp_sum(longint'(sum_x) + longint'(s.sample) * q14_sin(deg));
    sum_y  = clamp_sum(longint'(sum_y) + longint'(s.sample) * q14_sin(deg + 90));
    if (s.sample > ring_thr && hits != HitMax) hits++;
    if (!s.last) return;
    if (hits == 0) begin
      bearing = -1;
    end else if (sum_x == 0 && sum_y == 0) begin
      bearing = 90;
    end else begin
      x = sum_x;
      y = sum_y;
      bearing = 0;
      // first sector whose lower ray has the vector on its left side
      for (int d = 0; d < 360; d++) begin
        c0 = x * q14_sin(d + 90) - y * q14_sin(d);
        c1 = x * q14_sin(d + 91) - y * q14_sin(d + 1);
        if (c0 >= 0 && c1 < 0) begin
          bearing = (d < 270 || c0 == 0) ? d : (d + 1) % 360;
          break;
        end
      end
    end
    res.present = (hits != 0);
    res.angle   = AngleBits'(bearing);
    res.right   = s.right > side_thr;
    res.left    = s.left > side_thr;
    res.back    = s.back > side_thr;
    sum_x = '0;
    sum_y = '0;
    hits  = '0;
  endtask

  // drives the sample, waits out any idle gap and input stall, returns once it is taken
  task automatic put_sample(input ring_item_t s, input logic typed,
                            input line_result_t typed_want);
    int unsigned  gap;
    logic         closes;
    line_result_t calc;
    gap = idle_on ? $urandom_range(0, 7) : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i          <= 1'b1;
    ring_sample_i       <= s.sample;
    sensor_index_i      <= s.idx;
    frame_last_i        <= s.last;
    side_right_sample_i <= s.right;
    side_left_sample_i  <= s.left;
    side_back_sample_i  <= s.back;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    fold_ring_sample(s, closes, calc);
    if (closes) line_queue.push_back(typed ? typed_want : calc);
  endtask

  task automatic settle();
    in_valid_i <= 1'b0;
    while (line_queue.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_thresholds(input logic [ThrBits-1:0] ring_val,
                                  input logic [ThrBits-1:0] side_val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= RegRingThr;
    cfg_data_i  <= ring_val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    ring_thr    = ring_val;
    cfg_index_i <= RegSideThr;
    cfg_data_i  <= side_val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    side_thr    = side_val;
    cfg_valid_i <= 1'b0;
  endtask

  task automatic note_fault(input string what, input line_result_t want,
                            input line_result_t seen);
    fault_count++;
    if (fault_count <= 10) begin
      $display("%s: expected p%0b a%0d r%0b l%0b b%0b, got p%0b a%0d r%0b l%0b b%0b",
               what, want.present, want.angle, want.right, want.left, want.back,
               seen.present, seen.angle, seen.right, seen.left, seen.back);
    end
  endtask

  // result side: check each transaction, then hold off the next one a while
  always @(posedge clk_i) begin : result_check
    line_result_t seen;
    line_result_t want;
    if (!rst_ni) begin
      hold_left = 0;
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        seen = '{line_present_o, line_angle_o, side_right_o, side_left_o, side_back_o};
        if (line_queue.size() == 0) begin
          note_fault("unexpected result", NoLine, seen);
        end else begin
          want = line_queue.pop_front();
          if (seen !== want) note_fault("result mismatch", want, seen);
        end
        hold_left = stall_on ? $urandom_range(0, 7) : 0;
      end else if (out_valid_o && hold_left > 0) begin
        hold_left--;
      end
      out_stall_i <= (hold_left > 0);
    end
  end

  initial begin : stimulus
    ring_item_t s;
    int sent;
    int kind;
    int len;
    int centre;
    int width;
    int ring_off;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int r = 0; r < DirCount; r++) begin
      put_sample(DirRows[r].item, DirRows[r].typed, DirRows[r].want);
    end
    settle();

    for (int p = 1; p <= 8; p++) begin
      case (p)
        1: write_thresholds(10'd0, 10'd0);
        2: write_thresholds(10'd1023, 10'd1023);
        3: write_thresholds(10'd1023, 10'd0);
        4: write_thresholds(10'd0, 10'd1023);
        default: write_thresholds(ThrBits'($urandom_range(0, 1000)),
                                  ThrBits'($urandom_range(0, 1023)));
      endcase
      sent = 0;
      while (sent < 80) begin
        idle_on  = ($urandom_range(0, 3) != 0);
        stall_on = ($urandom_range(0, 3) != 0);
        kind     = $urandom_range(0, 99);
        if (sent == 0 && (p == 5 || p == 7)) begin
          // one sensor at full scale long enough to pin a sum and the hit count
          len = 140;
          for (int i = 0; i < len; i++) begin
            s.sample = '1;
            s.idx    = (p == 5) ? IndexBits'(0) : IndexBits'(12);
            s.last   = (i == len - 1);
            s.right  = ThrBits'($urandom_range(0, 1023));
            s.left   = ThrBits'($urandom_range(0, 1023));
            s.back   = ThrBits'($urandom_range(0, 1023));
            put_sample(s, 1'b0, NoLine);
          end
        end else if (kind < 60) begin
          // ordered ring sweep, mostly a line over a few neighbouring sensors
          len    = SensorCount;
          centre = $urandom_range(0, SensorCount - 1);
          width  = $urandom_range(0, 3);
          for (int i = 0; i < len; i++) begin
            ring_off = (i - centre + SensorCount) % SensorCount;
            if (ring_off > SensorCount / 2) ring_off = SensorCount - ring_off;
            if (kind < 20) s.sample = SampleBits'($urandom_range(0, 1023));
            else if (ring_off <= width) s.sample = SampleBits'($urandom_range(600, 1023));
            else s.sample = SampleBits'($urandom_range(0, 300));
            s.idx   = IndexBits'(i);
            s.last  = (i == len - 1);
            s.right = ThrBits'($urandom_range(0, 1023));
            s.left  = ThrBits'($urandom_range(0, 1023));
            s.back  = ThrBits'($urandom_range(0, 1023));
            put_sample(s, 1'b0, NoLine);
          end
        end else begin
          // short or scattered frames, repeated and skipped sensors allowed
          len = (kind < 75) ? 1 : $urandom_range(2, 24);
          for (int i = 0; i < len; i++) begin
            s.sample = SampleBits'($urandom_range(0, 1023));
            s.idx    = IndexBits'($urandom_range(0, SensorCount - 1));
            s.last   = (i == len - 1);
            s.right  = ThrBits'($urandom_range(0, 1023));
            s.left   = ThrBits'($urandom_range(0, 1023));
            s.back   = ThrBits'($urandom_range(0, 1023));
            put_sample(s, 1'b0, NoLine);
          end
        end
        sent += len;
      end
      settle();
    end

    repeat (760) @(posedge clk_i);
    if (fault_count == 0 && line_queue.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
